// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

   localparam int RAW_W       = 20;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int TEMP_W      = 15;
   localparam int FINE_W      = 20;
   localparam int PRES_W      = 25;

   // pressure keeps this many fraction bits before the output shift
   localparam int MODEL_FRAC_BITS         = 8;
   localparam int PRESSURE_FRAC_BITS_DEF  = 8;

   // long division: dividend, divisor and quotient widths
   localparam int NUM_W = 68;
   localparam int DEN_W = 31;
   localparam int Q_W   = 33;

   localparam int Q_COEF = 3125;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_T1    = 3'd0,
      CSR_CAL_T2_T3 = 3'd1,
      CSR_CAL_P1    = 3'd2,
      CSR_CAL_P2_P3 = 3'd3,
      CSR_CAL_P4_P5 = 3'd4,
      CSR_CAL_P6_P7 = 3'd5,
      CSR_CAL_P8_P9 = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [FINE_W-1:0] fine;
   } side_type;

   typedef struct packed {
      side_type side;
      logic     neg;
      logic     zero;
   } div_tag_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [FINE_W-1:0] fine;
      logic [PRES_W-1:0]        pres;
      logic                     zero;
   } rsp_type;

endpackage

// ===== hdl/bpc_if.sv =====
interface bpc_req_if;
   import bpc_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_temperature;
   logic [RAW_W-1:0] raw_pressure;
   modport source (output valid, raw_temperature, raw_pressure, input ready);
   modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_rsp_if;
   import bpc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centideg;
   logic signed [FINE_W-1:0] fine_temperature;
   logic [PRES_W-1:0]        pressure_pa_q8;
   logic                     divisor_zero;
   modport source (output valid, temperature_centideg, fine_temperature, pressure_pa_q8,
                   divisor_zero, input ready);
   modport sink   (input valid, temperature_centideg, fine_temperature, pressure_pa_q8,
                   divisor_zero, output ready);
endinterface

interface bpc_csr_if;
   import bpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bpc_div.sv =====
module bpc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [bpc_pkg::NUM_W-1:0]   num,
   input  logic [bpc_pkg::DEN_W-1:0]   den,
   input  bpc_pkg::div_tag_type        in_tag,
   output logic                        out_valid,
   output logic [bpc_pkg::Q_W-1:0]     quo,
   output bpc_pkg::div_tag_type        out_tag
);
   import bpc_pkg::*;

   localparam int STEPS = Q_W;
   localparam logic [Q_W-1:0] Q_LIM = {1'b1, {(Q_W-1){1'b0}}};

   logic [STEPS:0]   vld_ff;
   logic [STEPS:0]   big_ff;
   logic [DEN_W-1:0] rem_ff [STEPS+1];
   logic [DEN_W-1:0] den_ff [STEPS+1];
   logic [Q_W-1:0]   quo_ff [STEPS+1];
   logic [Q_W-1:0]   low_ff [STEPS];
   div_tag_type      tag_ff [STEPS+1];
   logic             big_in;

   // quotient of 2^33 or more: saturates anyway
   assign big_in = num >= {{(NUM_W-DEN_W-Q_W){1'b0}}, den, {Q_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big_ff[0] <= big_in;
         rem_ff[0] <= num[Q_W+DEN_W-1:Q_W];
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         low_ff[0] <= num[Q_W-1:0];
         tag_ff[0] <= in_tag;
      end
   end

   // one restoring step per stage
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      assign trial  = {rem_ff[k-1], low_ff[k-1][Q_W-1]};
      assign diff   = trial - {1'b0, den_ff[k-1]};
      assign ge     = trial >= {1'b0, den_ff[k-1]};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            big_ff[k] <= big_ff[k-1];
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= {quo_ff[k-1][Q_W-2:0], ge};
            tag_ff[k] <= tag_ff[k-1];
         end
      end

      if (k < STEPS) begin : g_low
         always_ff @(posedge clock) begin
            if (en) begin
               low_ff[k] <= {low_ff[k-1][Q_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_tag   = tag_ff[STEPS];
   assign quo       = (big_ff[STEPS] || quo_ff[STEPS] > Q_LIM) ? Q_LIM : quo_ff[STEPS];

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STEPS] && !big_ff[STEPS] && den_ff[STEPS] != '0 |->
         rem_ff[STEPS] < den_ff[STEPS])
      else $error("division remainder not below divisor");

   a_zero_den_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid && den_ff[STEPS] == '0 |-> quo == Q_LIM)
      else $error("zero divisor did not saturate quotient");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("divider valid bits moved during stall");

endmodule

// ===== hdl/baro_temp_pressure_compensation_top.sv =====
// Barometric temperature / pressure compensation.
// req_if : one transaction carries a raw 20-bit temperature and pressure sample.
// rsp_if : one transaction per request, in order: temperature in 0.01 degC,
//          the fine temperature term, pressure in Pa (Q.PRESSURE_FRAC_BITS) and a
//          flag raised when the pressure divisor is zero (pressure then reads 0).
// csr_if : writes to the seven calibration registers, always ready; write them
//          only while no request is in flight. Out-of-range indices are dropped.
// Throughput: one transaction per cycle while the output buffer has room. From
//   accept to rsp_if.valid: 11 polynomial stages, a 34-stage restoring divider
//   (capture, then a quotient bit per stage), 4 correction stages, output buffer.
// Stall: the whole pipe advances on one enable that drops only when the
//   2-entry output buffer is full, so a request is still taken while one
//   result waits for rsp_if.ready; nothing is dropped or repeated.
// Reset: clears all valid bits, the output buffer and the calibration
//   registers (all zero), so the first results show divisor_zero until P1 is set.
module baro_temp_pressure_compensation_top #(
   parameter int PRESSURE_FRAC_BITS = bpc_pkg::PRESSURE_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bpc_req_if.sink   req_if,
   bpc_rsp_if.source rsp_if,
   bpc_csr_if.sink   csr_if
);
   import bpc_pkg::*;

   localparam int PRE_N  = 11;
   localparam int POST_N = 4;
   localparam logic signed [23:0] TF_LO   = -24'sd262144;
   localparam logic signed [23:0] TF_HI   = 24'sd524287;
   localparam logic signed [15:0] TEMP_LO = -16'sd4000;
   localparam logic signed [15:0] TEMP_HI = 16'sd8500;
   localparam logic signed [28:0] PRES_HI = 29'sd33554431;

   // ---------------- calibration registers ----------------
   logic [15:0] cal_t1_ff, cal_p1_ff;
   logic [31:0] cal_t2_t3_ff, cal_p2_p3_ff, cal_p4_p5_ff, cal_p6_p7_ff, cal_p8_p9_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t1_ff    <= '0;
         cal_t2_t3_ff <= '0;
         cal_p1_ff    <= '0;
         cal_p2_p3_ff <= '0;
         cal_p4_p5_ff <= '0;
         cal_p6_p7_ff <= '0;
         cal_p8_p9_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_CAL_T1:    cal_t1_ff    <= csr_if.data[15:0];
            CSR_CAL_T2_T3: cal_t2_t3_ff <= csr_if.data;
            CSR_CAL_P1:    cal_p1_ff    <= csr_if.data[15:0];
            CSR_CAL_P2_P3: cal_p2_p3_ff <= csr_if.data;
            CSR_CAL_P4_P5: cal_p4_p5_ff <= csr_if.data;
            CSR_CAL_P6_P7: cal_p6_p7_ff <= csr_if.data;
            CSR_CAL_P8_P9: cal_p8_p9_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   logic        [15:0] t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = cal_t1_ff;
   assign t2 = cal_t2_t3_ff[31:16];
   assign t3 = cal_t2_t3_ff[15:0];
   assign p1 = cal_p1_ff;
   assign p2 = cal_p2_p3_ff[31:16];
   assign p3 = cal_p2_p3_ff[15:0];
   assign p4 = cal_p4_p5_ff[31:16];
   assign p5 = cal_p4_p5_ff[15:0];
   assign p6 = cal_p6_p7_ff[31:16];
   assign p7 = cal_p6_p7_ff[15:0];
   assign p8 = cal_p8_p9_ff[31:16];
   assign p9 = cal_p8_p9_ff[15:0];

   // ---------------- flow control ----------------
   logic             en, accept, push, pop, full;
   logic [PRE_N-1:0] pre_vld_ff;
   logic [POST_N-1:0] post_vld_ff;
   logic [1:0]       cnt_ff;

   assign full         = cnt_ff == 2'd2;
   assign en           = !full;
   assign req_if.ready = en;
   assign accept       = req_if.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (en) begin
         pre_vld_ff <= {pre_vld_ff[PRE_N-2:0], accept};
      end
   end

   // ---------------- s1: capture ----------------
   logic [RAW_W-1:0] adc_t_s1_ff;
   logic [RAW_W-1:0] adc_p_ff [8];   // raw pressure rides along to s8

   always_ff @(posedge clock) begin
      if (en) begin
         adc_t_s1_ff <= req_if.raw_temperature;
         adc_p_ff[0] <= req_if.raw_pressure;
         for (int i = 1; i < 8; i++) begin
            adc_p_ff[i] <= adc_p_ff[i-1];
         end
      end
   end

   // ---------------- s2: temperature products ----------------
   logic signed [17:0] ta;
   logic signed [16:0] dt;
   logic signed [33:0] ta_prod_in, dd_full;
   logic signed [33:0] ta_prod_s2_ff;
   logic [31:0]        dd_s2_ff;

   assign ta         = $signed({1'b0, adc_t_s1_ff[19:3]}) - $signed({1'b0, t1, 1'b0});
   assign dt         = $signed({1'b0, adc_t_s1_ff[19:4]}) - $signed({1'b0, t1});
   assign ta_prod_in = ta * t2;
   assign dd_full    = dt * dt;

   always_ff @(posedge clock) begin
      if (en) begin
         ta_prod_s2_ff <= ta_prod_in;
         dd_s2_ff      <= dd_full[31:0];
      end
   end

   // ---------------- s3 ----------------
   logic signed [36:0] b_prod_in, b_prod_s3_ff;
   logic signed [22:0] a_s3_ff;

   assign b_prod_in = $signed({1'b0, dd_s2_ff[31:12]}) * t3;

   always_ff @(posedge clock) begin
      if (en) begin
         a_s3_ff      <= ta_prod_s2_ff[33:11];
         b_prod_s3_ff <= b_prod_in;
      end
   end

   // ---------------- s4: fine temperature, saturated ----------------
   logic signed [23:0] tf_sum;
   logic signed [19:0] tf_in, tf_s4_ff;

   assign tf_sum = $signed({a_s3_ff[22], a_s3_ff})
                 + $signed({b_prod_s3_ff[36], b_prod_s3_ff[36:14]});

   always_comb begin
      if (tf_sum < TF_LO) begin
         tf_in = TF_LO[19:0];
      end else if (tf_sum > TF_HI) begin
         tf_in = TF_HI[19:0];
      end else begin
         tf_in = tf_sum[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tf_s4_ff <= tf_in;
      end
   end

   // ---------------- s5: centidegrees and pressure offset ----------------
   logic [23:0]        tfx, t5;
   logic signed [15:0] t8;
   logic signed [14:0] temp_in;
   logic signed [20:0] v21;
   logic signed [19:0] v_s5_ff;
   side_type           side_ff [7];   // s5 .. s11

   assign tfx = {{4{tf_s4_ff[19]}}, tf_s4_ff};
   assign t5  = (tfx << 2) + tfx + 24'd128;
   assign t8  = $signed(t5[23:8]);
   assign v21 = $signed({tf_s4_ff[19], tf_s4_ff}) - 21'sd128000;

   always_comb begin
      if (t8 < TEMP_LO) begin
         temp_in = TEMP_LO[14:0];
      end else if (t8 > TEMP_HI) begin
         temp_in = TEMP_HI[14:0];
      end else begin
         temp_in = t8[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_s5_ff      <= v21[19:0];
         side_ff[0]   <= '{temp: temp_in, fine: tf_s4_ff};
         for (int i = 1; i < 7; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------- s6: v products ----------------
   logic signed [39:0] vv_full;
   logic signed [35:0] vp5_in, vp2_in, vp5_s6_ff, vp2_s6_ff;
   logic [37:0]        vv_s6_ff;

   assign vv_full = v_s5_ff * v_s5_ff;
   assign vp5_in  = v_s5_ff * p5;
   assign vp2_in  = v_s5_ff * p2;

   always_ff @(posedge clock) begin
      if (en) begin
         vv_s6_ff  <= vv_full[37:0];
         vp5_s6_ff <= vp5_in;
         vp2_s6_ff <= vp2_in;
      end
   end

   // ---------------- s7: v^2 products ----------------
   logic signed [54:0] vvp6_in, vvp3_in, vvp6_s7_ff, vvp3_s7_ff;
   logic signed [35:0] vp5_s7_ff, vp2_s7_ff;

   assign vvp6_in = $signed({1'b0, vv_s6_ff}) * p6;
   assign vvp3_in = $signed({1'b0, vv_s6_ff}) * p3;

   always_ff @(posedge clock) begin
      if (en) begin
         vvp6_s7_ff <= vvp6_in;
         vvp3_s7_ff <= vvp3_in;
         vp5_s7_ff  <= vp5_s6_ff;
         vp2_s7_ff  <= vp2_s6_ff;
      end
   end

   // ---------------- s8: numerator offset w and divisor base ----------------
   logic [56:0] w_in, w_s8_ff;
   logic [50:0] s_in;
   logic signed [50:0] s_s8_ff;

   assign w_in = {{2{vvp6_s7_ff[54]}}, vvp6_s7_ff}
               + {{4{vp5_s7_ff[35]}}, vp5_s7_ff, 17'b0}
               + {{6{p4[15]}}, p4, 35'b0};
   assign s_in = {4'b0001, 47'b0}
               + {{4{vvp3_s7_ff[54]}}, vvp3_s7_ff[54:8]}
               + {{3{vp2_s7_ff[35]}}, vp2_s7_ff, 12'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         w_s8_ff <= w_in;
         s_s8_ff <= s_in;
      end
   end

   // ---------------- s9: divisor and numerator ----------------
   logic signed [67:0] den_full;
   logic [20:0]        pdiff;
   logic [57:0]        n_in, n_s9_ff;
   logic [DEN_W-1:0]   den_s9_ff;

   // low 64 bits of the product match the wrapped unsigned multiply
   assign den_full = s_s8_ff * $signed({1'b0, p1});
   assign pdiff    = 21'h100000 - {1'b0, adc_p_ff[7]};
   assign n_in     = {6'b0, pdiff, 31'b0} - {w_s8_ff[56], w_s8_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         den_s9_ff <= den_full[63:33];
         n_s9_ff   <= n_in;
      end
   end

   // ---------------- s10: magnitude ----------------
   logic [57:0]      n_abs;
   logic [55:0]      m_s10_ff;
   logic             neg_s10_ff, zero_s10_ff;
   logic [DEN_W-1:0] den_s10_ff;

   assign n_abs = n_s9_ff[57] ? (58'd0 - n_s9_ff) : n_s9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m_s10_ff    <= n_abs[55:0];
         neg_s10_ff  <= n_s9_ff[57];
         zero_s10_ff <= den_s9_ff == '0;
         den_s10_ff  <= den_s9_ff;
      end
   end

   // ---------------- s11: scale by 3125 ----------------
   logic [NUM_W-1:0] num_in, num_s11_ff;
   logic             neg_s11_ff, zero_s11_ff;
   logic [DEN_W-1:0] den_s11_ff;

   assign num_in = NUM_W'(m_s10_ff) * NUM_W'(Q_COEF);

   always_ff @(posedge clock) begin
      if (en) begin
         num_s11_ff  <= num_in;
         neg_s11_ff  <= neg_s10_ff;
         zero_s11_ff <= zero_s10_ff;
         den_s11_ff  <= den_s10_ff;
      end
   end

   // ---------------- divider ----------------
   logic        div_valid;
   logic [Q_W-1:0] div_quo;
   div_tag_type div_tag_in, div_tag;

   assign div_tag_in = '{side: side_ff[6], neg: neg_s11_ff, zero: zero_s11_ff};

   bpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pre_vld_ff[PRE_N-1]),
      .num       (num_s11_ff),
      .den       (den_s11_ff),
      .in_tag    (div_tag_in),
      .out_valid (div_valid),
      .quo       (div_quo),
      .out_tag   (div_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else if (en) begin
         post_vld_ff <= {post_vld_ff[POST_N-2:0], div_valid};
      end
   end

   div_tag_type ptag_ff [POST_N];

   always_ff @(posedge clock) begin
      if (en) begin
         ptag_ff[0] <= div_tag;
         for (int i = 1; i < POST_N; i++) begin
            ptag_ff[i] <= ptag_ff[i-1];
         end
      end
   end

   // ---------------- p1: signed quotient ----------------
   logic [33:0]        q_in;
   logic signed [33:0] q_p1_ff, q_p2_ff, q_p3_ff;

   assign q_in = div_tag.neg ? (34'd0 - {1'b0, div_quo}) : {1'b0, div_quo};

   always_ff @(posedge clock) begin
      if (en) begin
         q_p1_ff <= q_in;
      end
   end

   // ---------------- p2: q^2 and P8 term ----------------
   logic signed [20:0] qs;
   logic signed [41:0] qs2_full;
   logic signed [49:0] p8q_in, p8q_p2_ff, p8q_p3_ff;
   logic [38:0]        qs2_p2_ff;

   assign qs       = q_p1_ff[33:13];
   assign qs2_full = qs * qs;
   assign p8q_in   = p8 * q_p1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         qs2_p2_ff <= qs2_full[38:0];
         p8q_p2_ff <= p8q_in;
         q_p2_ff   <= q_p1_ff;
      end
   end

   // ---------------- p3: P9 term ----------------
   logic signed [55:0] p9qq_in, p9qq_p3_ff;

   assign p9qq_in = p9 * $signed({1'b0, qs2_p2_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         p9qq_p3_ff <= p9qq_in;
         p8q_p3_ff  <= p8q_p2_ff;
         q_p3_ff    <= q_p2_ff;
      end
   end

   // ---------------- p4: corrected quotient ----------------
   logic [35:0]        r_in;
   logic signed [35:0] r_p4_ff;

   assign r_in = {{2{q_p3_ff[33]}}, q_p3_ff}
               + {{5{p9qq_p3_ff[55]}}, p9qq_p3_ff[55:25]}
               + {{5{p8q_p3_ff[49]}}, p8q_p3_ff[49:19]};

   always_ff @(posedge clock) begin
      if (en) begin
         r_p4_ff <= r_in;
      end
   end

   // ---------------- p5: offset, scale, saturate into output buffer ----------------
   logic signed [28:0] pr_sum, pr_shift;
   logic [PRES_W-1:0]  pres;
   rsp_type            rsp_in;

   assign pr_sum   = $signed({r_p4_ff[35], r_p4_ff[35:8]})
                   + $signed({{9{p7[15]}}, p7, 4'b0});
   assign pr_shift = pr_sum >>> (MODEL_FRAC_BITS - PRESSURE_FRAC_BITS);

   always_comb begin
      if (ptag_ff[POST_N-1].zero || pr_shift < 29'sd0) begin
         pres = '0;
      end else if (pr_shift > PRES_HI) begin
         pres = '1;
      end else begin
         pres = pr_shift[PRES_W-1:0];
      end
   end

   assign rsp_in = '{temp: ptag_ff[POST_N-1].side.temp,
                     fine: ptag_ff[POST_N-1].side.fine,
                     pres: pres,
                     zero: ptag_ff[POST_N-1].zero};

   // ---------------- 2-entry output buffer ----------------
   rsp_type fifo_ff [2];
   logic    wr_ptr_ff, rd_ptr_ff;

   assign push = post_vld_ff[POST_N-1] && en;
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   assign rsp_if.valid                = cnt_ff != 2'd0;
   assign rsp_if.temperature_centideg = fifo_ff[rd_ptr_ff].temp;
   assign rsp_if.fine_temperature     = fifo_ff[rd_ptr_ff].fine;
   assign rsp_if.pressure_pa_q8       = fifo_ff[rd_ptr_ff].pres;
   assign rsp_if.divisor_zero         = fifo_ff[rd_ptr_ff].zero;

   // ---------------- checks ----------------
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("output buffer overflow");

   a_zero_pres: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.divisor_zero |-> rsp_if.pressure_pa_q8 == '0)
      else $error("pressure not forced to zero on zero divisor");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.temperature_centideg >= $signed(TEMP_LO[14:0])
                    && rsp_if.temperature_centideg <= $signed(TEMP_HI[14:0]))
      else $error("temperature outside saturation range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(post_vld_ff) && $stable(pre_vld_ff))
      else $error("pipeline moved while stalled");

endmodule
